### sv/assert_macros.svh
// Assertion macros for the port-level checker file, alfe_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/alfe_pkg.sv
// Shared types and constants of the addressable LED frame encoder.
// Used by the controller, the datapath, the top level and the checker.
package alfe_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] CFG_ONE_DUTY    = 2'd0;
    localparam logic [1:0] CFG_ZERO_DUTY   = 2'd1;
    localparam logic [1:0] CFG_RESET_SLOTS = 2'd2;
    localparam logic [1:0] CFG_LEDS_IN_USE = 2'd3;

    localparam logic [7:0] ONE_DUTY_RST    = 8'd66;
    localparam logic [7:0] ZERO_DUTY_RST   = 8'd33;
    localparam logic [7:0] RESET_SLOTS_RST = 8'd50;
    localparam logic [6:0] LEDS_IN_USE_RST = 7'd64;

    localparam int COLOR_W    = 24;
    localparam int GREEN_LSB  = 16;
    localparam int RED_LSB    = 8;
    localparam logic [4:0] BIT_TOP = 5'd23;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } enc_in_t;

    typedef struct packed {
        logic [7:0] duty;
        logic       active;
        logic       last_slot;
    } enc_out_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
    } dp_status_t;

endpackage

### sv/addressable_led_frame_encoder_core.sv
// Addressable LED frame encoder: a word is accepted only while idle, and busy
// stays high until its execute step ends; a tick's result is registered in
// result_reg, flagged by result_strobe for one cycle; the stored color is read
// ahead through the registered memory port at the current LED pointer.
// Reset is asynchronous, active low; afterwards a clearing pass writes black to
// all LED_COUNT memory entries, one per cycle, with busy high; config is taken.
module addressable_led_frame_encoder_core #(
    parameter int LED_COUNT = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  alfe_pkg::enc_in_t  request,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_wdata,
    output alfe_pkg::enc_out_t result,
    output logic               result_strobe
);
    import alfe_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    alfe_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    alfe_datapath #(
        .LED_COUNT (LED_COUNT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .request       (request),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

### sv/alfe_ctrl.sv
// Controller state machine: clearing pass, idle, execute.
// Depends on alfe_pkg for the command and status structs.
module alfe_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  alfe_pkg::dp_status_t  status,
    output alfe_pkg::ctrl_cmd_t   cmd,
    output logic                  busy
);
    import alfe_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    assign cmd.clear   = (state_reg == ST_CLEAR);
    assign cmd.capture = (state_reg == ST_IDLE) && start;
    assign cmd.exec    = (state_reg == ST_EXEC);
    assign busy        = (state_reg != ST_IDLE);

endmodule

### sv/alfe_datapath.sv
// Datapath: color memory, config registers, frame pointers, result register.
// Depends on alfe_pkg; driven by alfe_ctrl through ctrl_cmd_t.
module alfe_datapath #(
    parameter int LED_COUNT = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  alfe_pkg::ctrl_cmd_t   cmd,
    output alfe_pkg::dp_status_t  status,
    input  alfe_pkg::enc_in_t     request,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_wdata,
    output alfe_pkg::enc_out_t    result,
    output logic                  result_strobe
);
    import alfe_pkg::*;

    localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int PW = $clog2(LED_COUNT + 1);
    localparam int CW = (PW > 7) ? PW : 7;

    logic [COLOR_W-1:0] color_mem [LED_COUNT];
    logic [COLOR_W-1:0] rd_data_reg;
    logic [AW-1:0]      clear_addr_reg;
    logic [AW-1:0]      rd_addr;

    enc_in_t    item_reg;
    logic [7:0] one_duty_reg;
    logic [7:0] zero_duty_reg;
    logic [7:0] reset_slots_reg;
    logic [6:0] leds_in_use_reg;

    logic          running_reg, running_next;
    logic [PW-1:0] led_ptr_reg, led_ptr_next;
    logic [4:0]    bit_ptr_reg, bit_ptr_next;
    logic [7:0]    tail_reg, tail_next;
    logic [PW-1:0] frame_leds_reg, frame_leds_next;
    logic [7:0]    frame_tail_reg, frame_tail_next;

    enc_out_t   result_reg, result_next;
    logic       result_strobe_reg;

    logic          wr_en;
    logic [PW-1:0] leds_sat;
    logic          is_tick;

    assign status.clear_done = (clear_addr_reg == AW'(LED_COUNT - 1));

    assign wr_en = cmd.exec && (item_reg.command == CMD_WRITE) && !running_reg
                   && (CW'(item_reg.led_index) < CW'(LED_COUNT));

    assign rd_addr = (CW'(led_ptr_reg) < CW'(LED_COUNT)) ? led_ptr_reg[AW-1:0] : '0;

    // Saturate the requested LED count to the store size.
    assign leds_sat = (CW'(leds_in_use_reg) > CW'(LED_COUNT)) ? PW'(LED_COUNT)
                                                             : PW'(leds_in_use_reg);

    assign is_tick = cmd.exec && (item_reg.command == CMD_TICK);

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
            color_mem[clear_addr_reg] <= '0;
        else if (wr_en)
            color_mem[AW'(item_reg.led_index)] <=
                {item_reg.green, item_reg.red, item_reg.blue};
        rd_data_reg <= color_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clear_addr_reg <= '0;
        else if (cmd.clear && !status.clear_done)
            clear_addr_reg <= clear_addr_reg + AW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= request;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_duty_reg    <= ONE_DUTY_RST;
            zero_duty_reg   <= ZERO_DUTY_RST;
            reset_slots_reg <= RESET_SLOTS_RST;
            leds_in_use_reg <= LEDS_IN_USE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ONE_DUTY:    one_duty_reg    <= cfg_wdata;
                CFG_ZERO_DUTY:   zero_duty_reg   <= cfg_wdata;
                CFG_RESET_SLOTS: reset_slots_reg <= cfg_wdata;
                CFG_LEDS_IN_USE: leds_in_use_reg <= cfg_wdata[6:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        running_next    = running_reg;
        led_ptr_next    = led_ptr_reg;
        bit_ptr_next    = bit_ptr_reg;
        tail_next       = tail_reg;
        frame_leds_next = frame_leds_reg;
        frame_tail_next = frame_tail_reg;
        result_next     = '0;

        if (cmd.exec && (item_reg.command == CMD_START) && !running_reg)
        begin
            // Drop a start that would send nothing at all.
            if ((leds_sat != '0) || (reset_slots_reg != 8'd0))
            begin
                frame_leds_next = leds_sat;
                frame_tail_next = reset_slots_reg;
                led_ptr_next    = '0;
                bit_ptr_next    = '0;
                tail_next       = '0;
                running_next    = 1'b1;
            end
        end

        if (is_tick && running_reg)
        begin
            result_next.active = 1'b1;
            if (led_ptr_reg < frame_leds_reg)
            begin
                result_next.duty = rd_data_reg[BIT_TOP - bit_ptr_reg] ? one_duty_reg
                                                                      : zero_duty_reg;
                if (bit_ptr_reg == BIT_TOP)
                begin
                    bit_ptr_next = '0;
                    led_ptr_next = led_ptr_reg + PW'(1);
                end
                else
                begin
                    bit_ptr_next = bit_ptr_reg + 5'd1;
                end
            end
            else
            begin
                tail_next = tail_reg + 8'd1;
            end

            if ((led_ptr_next >= frame_leds_reg) && (tail_next >= frame_tail_reg))
            begin
                result_next.last_slot = 1'b1;
                running_next = 1'b0;
                led_ptr_next = '0;
                bit_ptr_next = '0;
                tail_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg       <= 1'b0;
            led_ptr_reg       <= '0;
            bit_ptr_reg       <= '0;
            tail_reg          <= '0;
            frame_leds_reg    <= '0;
            frame_tail_reg    <= '0;
            result_strobe_reg <= 1'b0;
        end
        else
        begin
            running_reg       <= running_next;
            led_ptr_reg       <= led_ptr_next;
            bit_ptr_reg       <= bit_ptr_next;
            tail_reg          <= tail_next;
            frame_leds_reg    <= frame_leds_next;
            frame_tail_reg    <= frame_tail_next;
            result_strobe_reg <= is_tick;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
            result_reg <= result_next;
    end

    assign result        = result_reg;
    assign result_strobe = result_strobe_reg;

endmodule

### sv/alfe_checker.sv
// Port-level checker for the LED frame encoder, bound to the top level.
// Depends on alfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module alfe_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input alfe_pkg::enc_out_t result,
    input logic               result_strobe
);
    import alfe_pkg::*;

    logic accept;
    assign accept = start && !busy;

    `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy, "accepted word did not raise busy")
    `ASSERT_IMPLY(a_strobe_idle, clk, rst_n, result_strobe, !busy, "result while busy")
    `ASSERT_IMPLY(a_strobe_src, clk, rst_n, result_strobe, $past(accept, 2), "result w/o word")
    `ASSERT_IMPLY(a_last_active, clk, rst_n, result_strobe && result.last_slot, result.active,
                  "last slot outside a frame")

endmodule

bind addressable_led_frame_encoder_core alfe_checker u_alfe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result        (result),
    .result_strobe (result_strobe)
);

### dv/alfe_frame_checker.sv
`timescale 1ns / 1ps
// Checker for the addressable LED frame encoder: predicts every tick slot and compares it.
// Depends on alfe_pkg; watches the command, config and result ports of the core.
module alfe_frame_checker #(
    parameter int LED_COUNT = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  alfe_pkg::enc_in_t  request,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_wdata,
    input  alfe_pkg::enc_out_t result,
    input  logic               result_strobe,
    output int                 fail_count,
    output int                 slots_checked,
    output int                 frames_done,
    output int                 pending_slots,
    output logic               frame_open
);
    import alfe_pkg::*;

    logic [COLOR_W-1:0] color_mem [LED_COUNT];
    enc_out_t           expected_slots [$];

    logic [7:0] one_duty_q;
    logic [7:0] zero_duty_q;
    logic [7:0] tail_len_q;
    logic [6:0] leds_q;

    bit running;
    int led_ptr;
    int bit_ptr;
    int tail_cnt;
    int frame_leds;
    int frame_tail;

    task automatic take_reg(input logic [1:0] idx, input logic [7:0] val);
        case (idx)
            CFG_ONE_DUTY:    one_duty_q  = val;
            CFG_ZERO_DUTY:   zero_duty_q = val;
            CFG_RESET_SLOTS: tail_len_q  = val;
            CFG_LEDS_IN_USE: leds_q      = val[6:0];
            default: ;
        endcase
    endtask

    task automatic encode_word(input enc_in_t w);
        enc_out_t           slot;
        logic [COLOR_W-1:0] color;
        int                 n;
        slot = '0;
        case (w.command)
            CMD_WRITE: begin
                if (!running && int'(w.led_index) < LED_COUNT)
                    color_mem[w.led_index] = {w.green, w.red, w.blue};
            end
            CMD_START: begin
                n = int'(leds_q);
                if (n > LED_COUNT)
                    n = LED_COUNT;
                // an empty frame never starts
                if (!running && (n != 0 || tail_len_q != 0)) begin
                    frame_leds = n;
                    frame_tail = int'(tail_len_q);
                    led_ptr    = 0;
                    bit_ptr    = 0;
                    tail_cnt   = 0;
                    running    = 1'b1;
                end
            end
            CMD_TICK: begin
                if (running) begin
                    slot.active = 1'b1;
                    if (led_ptr < frame_leds) begin
                        color     = color_mem[led_ptr];
                        slot.duty = color[COLOR_W - 1 - bit_ptr] ? one_duty_q : zero_duty_q;
                        bit_ptr++;
                        if (bit_ptr == COLOR_W) begin
                            bit_ptr = 0;
                            led_ptr++;
                        end
                    end else begin
                        tail_cnt++;
                    end
                    if (led_ptr >= frame_leds && tail_cnt >= frame_tail) begin
                        slot.last_slot = 1'b1;
                        running        = 1'b0;
                        led_ptr        = 0;
                        bit_ptr        = 0;
                        tail_cnt       = 0;
                    end
                end
                expected_slots.push_back(slot);
            end
            default: ;
        endcase
    endtask

    task automatic check_slot(input enc_out_t got);
        enc_out_t want;
        slots_checked++;
        if (got.last_slot)
            frames_done++;
        if (expected_slots.size() == 0) begin
            $error("slot with nothing expected: duty %0d active %0b last_slot %0b",
                   got.duty, got.active, got.last_slot);
            fail_count++;
        end else begin
            want = expected_slots.pop_front();
            if (got.duty !== want.duty) begin
                $error("duty: expected %0d, got %0d", want.duty, got.duty);
                fail_count++;
            end
            if (got.active !== want.active) begin
                $error("active: expected %0b, got %0b", want.active, got.active);
                fail_count++;
            end
            if (got.last_slot !== want.last_slot) begin
                $error("last_slot: expected %0b, got %0b", want.last_slot, got.last_slot);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < LED_COUNT; i++)
                color_mem[i] = '0;
            expected_slots.delete();
            one_duty_q    = ONE_DUTY_RST;
            zero_duty_q   = ZERO_DUTY_RST;
            tail_len_q    = RESET_SLOTS_RST;
            leds_q        = LEDS_IN_USE_RST;
            running       = 1'b0;
            led_ptr       = 0;
            bit_ptr       = 0;
            tail_cnt      = 0;
            frame_leds    = 0;
            frame_tail    = 0;
            fail_count    = 0;
            slots_checked = 0;
            frames_done   = 0;
            pending_slots <= 0;
            frame_open    <= 1'b0;
        end else begin
            // compare first: a result never belongs to a word accepted at the same edge
            if (result_strobe)
                check_slot(result);
            if (cfg_wr_en)
                take_reg(cfg_index, cfg_wdata);
            if (start && !busy)
                encode_word(request);
            pending_slots <= expected_slots.size();
            frame_open    <= running;
        end
    end

endmodule

### dv/addressable_led_frame_encoder_core_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the addressable LED frame encoder core.
// Depends on alfe_pkg, the core and alfe_frame_checker, which does all the comparing.
module addressable_led_frame_encoder_core_test;
    import alfe_pkg::*;

    localparam int         LEDS        = 64;
    localparam logic [1:0] CMD_NONE    = 2'd3;
    localparam int         WORD_TARGET = 1250;

    logic     clk           = 1'b0;
    logic     rst_n         = 1'b0;
    logic     start         = 1'b0;
    logic     busy;
    enc_in_t  request       = '0;
    logic     cfg_wr_en     = 1'b0;
    logic [1:0] cfg_index   = '0;
    logic [7:0] cfg_wdata   = '0;
    enc_out_t result;
    logic     result_strobe;

    int   fail_count;
    int   slots_checked;
    int   frames_done;
    int   pending_slots;
    logic frame_open;

    int         words_sent = 0;
    bit         burst_mode = 1'b0;
    logic [7:0] leds_cfg   = {1'b0, LEDS_IN_USE_RST};
    logic [7:0] slots_cfg  = RESET_SLOTS_RST;

    addressable_led_frame_encoder_core #(.LED_COUNT(LEDS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .result        (result),
        .result_strobe (result_strobe)
    );

    alfe_frame_checker #(.LED_COUNT(LEDS)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .result        (result),
        .result_strobe (result_strobe),
        .fail_count    (fail_count),
        .slots_checked (slots_checked),
        .frames_done   (frames_done),
        .pending_slots (pending_slots),
        .frame_open    (frame_open)
    );

    always #5 clk = ~clk;

    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int frame_len();
        int n;
        n = int'(leds_cfg[6:0]);
        if (n > LEDS)
            n = LEDS;
        return n * COLOR_W + int'(slots_cfg);
    endfunction

    function automatic logic [7:0] pick_duty();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_RESET_SLOTS)
            slots_cfg = val;
        if (idx == CFG_LEDS_IN_USE)
            leds_cfg = val;
        @(posedge clk);
    endtask

    // write the registers picked by mask, then drop the enable
    task automatic program_regs(input logic [3:0] mask, input logic [7:0] one,
                                input logic [7:0] zero, input logic [7:0] slots,
                                input logic [7:0] leds);
        if (mask[CFG_ONE_DUTY])
            set_reg(CFG_ONE_DUTY, one);
        if (mask[CFG_ZERO_DUTY])
            set_reg(CFG_ZERO_DUTY, zero);
        if (mask[CFG_RESET_SLOTS])
            set_reg(CFG_RESET_SLOTS, slots);
        if (mask[CFG_LEDS_IN_USE])
            set_reg(CFG_LEDS_IN_USE, leds);
        cfg_wr_en <= 1'b0;
    endtask

    // hold start until the core takes the word; start stays high for a follow-on word
    task automatic send_word(input logic [1:0] cmd, input logic [5:0] idx,
                             input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input bit counted);
        enc_in_t w;
        w.command   = cmd;
        w.led_index = idx;
        w.red       = r;
        w.green     = g;
        w.blue      = b;
        request <= w;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (counted)
            words_sent++;
    endtask

    task automatic send_tick(input bit counted);
        send_word(CMD_TICK, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), counted);
    endtask

    task automatic pause();
        int r;
        int n;
        n = 0;
        if (!burst_mode) begin
            r = $urandom_range(0, 99);
            if (r >= 94)
                n = $urandom_range(8, 40);
            else if (r >= 70)
                n = $urandom_range(1, 3);
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // drain outstanding slots, let the pipeline empty, then wait for an idle core
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_slots != 0);
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic run_ticks(input int count, input bit noisy);
        for (int i = 0; i < count; i++) begin
            if (noisy && $urandom_range(0, 15) == 0) begin
                case ($urandom_range(0, 2))
                    0: send_word(CMD_WRITE, 6'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom), 1'b0);
                    1: send_word(CMD_START, 6'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom), 1'b0);
                    default: send_word(CMD_NONE, 6'($urandom), 8'($urandom), 8'($urandom),
                                       8'($urandom), 1'b0);
                endcase
                pause();
            end
            send_tick(1'b1);
            pause();
        end
    endtask

    initial begin
        int         nw;
        int         len;
        int         r;
        logic [7:0] leds_v;
        logic [7:0] slots_v;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // idle tick and the unused command under reset settings
        send_tick(1'b1);
        send_word(CMD_NONE, 6'h3F, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_tick(1'b1);
        settle();

        // one LED plus two reset slots; starts and writes during the frame are dropped
        program_regs(4'hF, 8'hFF, 8'h00, 8'd2, 8'd1);
        send_word(CMD_WRITE, 6'd0, 8'hFF, 8'h81, 8'h00, 1'b1);
        send_word(CMD_WRITE, 6'd63, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_word(CMD_START, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1);
        send_word(CMD_START, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0);
        send_word(CMD_WRITE, 6'd0, 8'h00, 8'h00, 8'h00, 1'b0);
        run_ticks(frame_len() + 1, 1'b0);
        settle();

        // empty frame: start is ignored
        program_regs(4'b1100, 8'h00, 8'h00, 8'd0, 8'd0);
        send_word(CMD_START, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1);
        send_tick(1'b1);
        settle();

        // no LEDs, only a single reset slot
        program_regs(4'b0100, 8'h00, 8'h00, 8'd1, 8'd0);
        send_word(CMD_START, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        settle();
        program_regs(4'b1000, 8'h00, 8'h00, 8'd0, 8'd2);

        while (words_sent < WORD_TARGET) begin
            settle();
            r = $urandom_range(0, 15);
            if (r == 0)
                leds_v = 8'd0;
            else if (r == 1)
                leds_v = 8'($urandom_range(4, 12));
            else
                leds_v = 8'($urandom_range(1, 3));
            r = $urandom_range(0, 15);
            if (r == 0)
                slots_v = 8'd0;
            else if (r == 1)
                slots_v = 8'd255;
            else
                slots_v = 8'($urandom_range(1, 6));
            program_regs(4'($urandom), pick_duty(), pick_duty(), slots_v, leds_v);
            burst_mode = ($urandom_range(0, 3) == 0);

            nw = $urandom_range(0, 6);
            for (int i = 0; i < nw; i++) begin
                send_word(CMD_WRITE,
                          $urandom_range(0, 1) ? 6'($urandom_range(0, 7)) : 6'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
                pause();
            end
            send_word(CMD_START, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
            pause();

            // now and then cut the frame short so it runs on into the next settings
            len = frame_len();
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(0, len);
            else
                len = len + $urandom_range(0, 2);
            run_ticks(len, 1'b1);
        end

        // finish any frame left running
        settle();
        burst_mode = 1'b0;
        while (frame_open) begin
            send_tick(1'b0);
            settle();
        end

        // full store with leds_in_use saturating; duties change halfway through
        program_regs(4'hF, 8'h00, 8'hFF, 8'h00, 8'hFF);
        send_word(CMD_WRITE, 6'd63, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        send_word(CMD_WRITE, 6'd32, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        send_word(CMD_START, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1);
        run_ticks(frame_len() / 2, 1'b0);
        settle();
        program_regs(4'b0011, 8'hA5, 8'h5A, 8'h00, 8'h00);
        run_ticks(frame_len() - frame_len() / 2 + 1, 1'b0);

        start <= 1'b0;
        for (int i = 0; i < 200 && pending_slots != 0; i++)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d words over many register settings; checked %0d slots, %0d frames done",
                 words_sent, slots_checked, frames_done);
        if (fail_count == 0 && pending_slots == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/alfe_pkg.sv
sv/alfe_ctrl.sv
sv/alfe_datapath.sv
sv/addressable_led_frame_encoder_core.sv
sv/alfe_checker.sv
dv/alfe_frame_checker.sv
dv/addressable_led_frame_encoder_core_test.sv
